// File: rtl/core/rtp_pkg.sv
// ---------------------------------------------------------------------------
// rtp_pkg
// Shared types, character codes and helpers for the radix integer text parser.
// ---------------------------------------------------------------------------
package rtp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;
	localparam int RADIX_W         = 6;

	localparam logic [APB_ADDR_W-1:0] ADDR_RADIX_MODE = 3'h0;

	localparam logic [RADIX_W-1:0] BASE_TWO   = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_EIGHT = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_TEN   = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] MODE_AUTO  = 6'd0;

	localparam int K_SHIFT = 10;
	localparam int M_SHIFT = 20;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UB = 8'h42;
	localparam logic [7:0] CH_LB = 8'h62;
	localparam logic [7:0] CH_UK = 8'h4B;
	localparam logic [7:0] CH_LK = 8'h6B;
	localparam logic [7:0] CH_UM = 8'h4D;
	localparam logic [7:0] CH_LM = 8'h6D;
	localparam logic [7:0] DIGIT_LETTER_OFS = 8'd10;

	typedef enum logic [1:0] {
		PH_START,
		PH_ZERO,
		PH_AUTO,
		PH_FIXED
	} phase_t;

	typedef enum logic [1:0] {
		SUF_NONE,
		SUF_K,
		SUF_M
	} suffix_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_CHAR,
		ST_BIG_DIGIT
	} status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_marker;
	} char_item_t;

	typedef struct packed {
		logic signed [31:0] parsed_value;
		logic [1:0]         parse_status;
	} result_item_t;

	typedef struct packed {
		logic               ok;
		logic [RADIX_W-1:0] value;
	} digit_t;

	function automatic digit_t char_digit(input logic [7:0] c);
		digit_t d;
		d.ok    = 1'b1;
		d.value = '0;
		if (c >= CH_0 && c <= CH_9) begin
			d.value = RADIX_W'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d.value = RADIX_W'(c - CH_LA + DIGIT_LETTER_OFS);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d.value = RADIX_W'(c - CH_UA + DIGIT_LETTER_OFS);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// File: rtl/core/rtp_core.sv
// ---------------------------------------------------------------------------
// rtp_core
// Parse state and per-character step: prefix detection, digit decode,
// multiply-add by the radix, suffix scaling and result formatting.
// ---------------------------------------------------------------------------
module rtp_core #(
	parameter int VALUE_WIDTH = rtp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  rtp_pkg::char_item_t           item,
	input  logic [rtp_pkg::RADIX_W-1:0]   radix_mode,
	output rtp_pkg::result_item_t         result
);
	import rtp_pkg::*;

	logic [VALUE_WIDTH-1:0] acc_q;
	logic [RADIX_W-1:0]     base_q;
	phase_t                 phase_q;
	suffix_t                suffix_q;
	status_t                err_q;

	logic [VALUE_WIDTH-1:0] nxt_acc;
	logic [RADIX_W-1:0]     nxt_base;
	phase_t                 nxt_phase;
	suffix_t                nxt_suffix;
	status_t                nxt_err;
	status_t                err_mid;
	logic                   do_auto;
	logic                   do_digit;
	digit_t                 dig;
	logic [VALUE_WIDTH-1:0] mac;
	logic [VALUE_WIDTH-1:0] scaled;
	logic [7:0]             c;

	assign c   = item.char_code;
	assign dig = char_digit(c);
	assign mac = acc_q * VALUE_WIDTH'(nxt_base) + VALUE_WIDTH'(dig.value);

	always_comb begin
		nxt_base   = base_q;
		nxt_phase  = phase_q;
		do_auto    = 1'b0;
		do_digit   = 1'b0;
		unique case (phase_q)
			PH_START: begin
				if (radix_mode == MODE_AUTO) begin
					if (c == CH_0) begin
						nxt_base  = BASE_EIGHT;
						nxt_phase = PH_ZERO;
					end else begin
						nxt_base  = BASE_TEN;
						nxt_phase = PH_AUTO;
						do_auto   = 1'b1;
					end
				end else begin
					nxt_base  = (radix_mode > BASE_MAX) ? BASE_MAX : radix_mode;
					nxt_phase = PH_FIXED;
					do_digit  = 1'b1;
				end
			end
			PH_ZERO: begin
				nxt_phase = PH_AUTO;
				if (c == CH_LX || c == CH_UX) begin
					nxt_base = BASE_HEX;
				end else if (c == CH_LB || c == CH_UB) begin
					nxt_base = BASE_TWO;
				end else begin
					nxt_base = BASE_EIGHT;
					do_auto  = 1'b1;
				end
			end
			PH_AUTO: begin
				do_auto = 1'b1;
			end
			PH_FIXED: begin
				do_digit = 1'b1;
			end
			default: begin
				do_digit = 1'b1;
			end
		endcase

		// a held K or M followed by more text is a digit too big for any auto base
		err_mid    = err_q;
		nxt_suffix = suffix_q;
		if (do_auto) begin
			if (suffix_q != SUF_NONE && err_q == ST_OK) begin
				err_mid = ST_BIG_DIGIT;
			end
			if (c == CH_UK || c == CH_LK) begin
				nxt_suffix = SUF_K;
			end else if (c == CH_UM || c == CH_LM) begin
				nxt_suffix = SUF_M;
			end else begin
				nxt_suffix = SUF_NONE;
				do_digit   = 1'b1;
			end
		end

		nxt_acc = acc_q;
		nxt_err = err_mid;
		if (do_digit) begin
			if (!dig.ok) begin
				if (err_mid == ST_OK) begin
					nxt_err = ST_BAD_CHAR;
				end
			end else if (dig.value >= nxt_base) begin
				if (err_mid == ST_OK) begin
					nxt_err = ST_BIG_DIGIT;
				end
			end else begin
				nxt_acc = mac;
			end
		end
	end

	always_comb begin
		unique case (suffix_q)
			SUF_K:   scaled = acc_q << K_SHIFT;
			SUF_M:   scaled = acc_q << M_SHIFT;
			default: scaled = acc_q;
		endcase
		if (err_q != ST_OK) begin
			scaled = '0;
		end
	end

	generate
		if (VALUE_WIDTH < 32) begin : g_extend
			assign result.parsed_value = {{(32-VALUE_WIDTH){scaled[VALUE_WIDTH-1]}}, scaled};
		end else begin : g_trunc
			assign result.parsed_value = scaled[31:0];
		end
	endgenerate

	assign result.parse_status = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			base_q   <= BASE_TEN;
			phase_q  <= PH_START;
			suffix_q <= SUF_NONE;
			err_q    <= ST_OK;
		end else if (step) begin
			if (item.end_marker) begin
				acc_q    <= '0;
				base_q   <= BASE_TEN;
				phase_q  <= PH_START;
				suffix_q <= SUF_NONE;
				err_q    <= ST_OK;
			end else begin
				acc_q    <= nxt_acc;
				base_q   <= nxt_base;
				phase_q  <= nxt_phase;
				suffix_q <= nxt_suffix;
				err_q    <= nxt_err;
			end
		end
	end

endmodule

// File: rtl/core/radix_integer_text_parser.sv
// ---------------------------------------------------------------------------
// radix_integer_text_parser
// Text to integer parser with radix prefix detection and K/M suffix.
//
// Takes one character per transaction and returns one result transaction
// when a transaction with end_marker set arrives. A new character is taken
// every cycle: each transaction lands in an input register, and when it
// advances out of it one multiply-add of the accumulator by the radix updates
// the parse state; the result register captures the core result when the
// end transaction advances out of the input register. The
// input stalls only when an end transaction waits in the input register while
// the previous result is still held in the result register. The radix_mode
// register (APB byte address 0) selects auto-detect (0) or a fixed radix
// (1 to 36); it is sampled at the first character of each string.
// ---------------------------------------------------------------------------
module radix_integer_text_parser #(
	parameter int VALUE_WIDTH = rtp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtp_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rtp_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rtp_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              char_valid,
	output logic                              char_stall,
	input  rtp_pkg::char_item_t               char_item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output rtp_pkg::result_item_t             result_item
);
	import rtp_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic               valid_s1;
	char_item_t         item_s1;
	logic               advance;
	result_item_t       core_result;
	logic               res_valid_q;
	result_item_t       res_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RADIX_MODE) ? APB_DATA_W'(radix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= MODE_AUTO;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_RADIX_MODE) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	assign advance    = valid_s1 && !(item_s1.end_marker && res_valid_q && result_stall);
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			item_s1 <= char_item;
		end
	end

	rtp_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.radix_mode(radix_q),
		.result    (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.end_marker) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_marker) begin
			res_q <= core_result;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

endmodule
